[hw/rtl/scdp_pkg.sv]
// Shared types and constants for the sparse column dot product block.
package scdp_pkg;

  localparam int PTR_W = 17;
  localparam int ROW_W = 10;
  localparam int ACC_W = 64;

  localparam logic [1:0] CMD_PTR   = 2'd0;
  localparam logic [1:0] CMD_ENTRY = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COLA,
    S_COLB,
    S_MERGE,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic fire;
  } mac_ctl_t;

endpackage

[hw/rtl/scdp_ram.sv]
// Generic RAM with one write port and two registered read ports.
module scdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/scdp_mac.sv]
// Registered multiplier followed by a saturating 64-bit accumulator.
module scdp_mac import scdp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mac_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic [ACC_W-1:0]       acc,
  output logic                   sat
);

  logic signed [2*VALUE_WIDTH-1:0] prod_full;
  logic signed [ACC_W-1:0]         prod;
  logic                            prod_valid;
  logic [ACC_W-1:0]                sum;
  logic                            ovf;
  logic [ACC_W-1:0]                acc_next;

  assign prod_full = $signed(a) * $signed(b);
  assign sum       = acc + prod;

  // Overflow only when both operands share a sign and the sum does not.
  assign ovf = (acc[ACC_W-1] == prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);

  always_comb begin
    if (!ovf) begin
      acc_next = sum;
    end else if (acc[ACC_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    prod <= ACC_W'(prod_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
      sat        <= 1'b0;
    end else if (ctl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
      sat        <= 1'b0;
    end else begin
      prod_valid <= ctl.fire;
      if (prod_valid) begin
        acc <= acc_next;
        sat <= sat | ovf;
      end
    end
  end

endmodule

[hw/rtl/sparse_column_dot_product.sv]
// Top level of the sparse column dot product block.
//
// One input channel (cmd_valid / cmd_stall) carries three kinds of beat:
// a column start pointer write, a nonzero entry write (row and value) and
// a dot product query naming column A and a neighbour code. Writes give
// no result. A query answers with one beat on the result channel
// (res_valid / res_stall) carrying the Q16.48 dot product and a
// saturation flag.
// A query reads both column bounds in the states S_COLA and S_COLB
// through the two read ports of the pointer RAM, then merges the row
// lists one step per cycle through the two read ports of the nonzero
// RAM. A query with no neighbour or an out-of-range column skips the
// column reads and the merge and goes straight to S_DONE. The next
// input beat can be taken once the result is loaded into the output
// register; the input is stalled while a query is in progress.
// The result sits in an output register; when the receiver stalls, it
// holds there, and a further query waits for it only at its last step.
// Reset clears the control state and the accumulator. The RAM contents
// are not cleared and must be written before they are read.
module sparse_column_dot_product import scdp_pkg::*; #(
  parameter int MAX_DIM     = 1024,
  parameter int MAX_NNZ     = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [1:0]          cmd,
  input  logic [15:0]         slot,
  input  logic [PTR_W-1:0]    pointer_value,
  input  logic [ROW_W-1:0]    row_index,
  input  logic signed [31:0]  entry_value,
  input  logic [9:0]          col_a,
  input  logic [10:0]         neighbour_code,
  output logic                res_valid,
  input  logic                res_stall,
  output logic signed [ACC_W-1:0] dot_product,
  output logic                saturated
);

  localparam int DIM_AW = $clog2(MAX_DIM + 1);
  localparam int NNZ_AW = $clog2(MAX_NNZ);
  localparam int CUR_W  = $clog2(MAX_NNZ + 1);
  localparam int CMP_W  = (CUR_W > PTR_W) ? CUR_W : PTR_W;
  localparam int NZ_W   = ROW_W + VALUE_WIDTH;

  state_t state, state_next;

  logic [CUR_W-1:0] k, k_next, ke, ke_next;
  logic [CUR_W-1:0] l, l_next, le, le_next;
  logic [10:0]      cb;

  logic             accept;
  logic             query_ok;
  logic             res_load;
  logic [31:0]      slot_w, ca_w, ca1_w, cb_w, cb1_w;

  logic              col_we;
  logic [DIM_AW-1:0] col_raddr_a, col_raddr_b;
  logic [PTR_W-1:0]  col_rdata_a, col_rdata_b;

  logic              nz_we;
  logic [NNZ_AW-1:0] nz_raddr_a, nz_raddr_b;
  logic [NZ_W-1:0]   nz_rdata_a, nz_rdata_b;
  logic [ROW_W-1:0]  row_a, row_b;

  mac_ctl_t          mac_ctl;
  logic [ACC_W-1:0]  acc;
  logic              acc_sat;

  function automatic logic [CUR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    logic [CMP_W-1:0] w;
    w = CMP_W'(p);
    if (w > CMP_W'(MAX_NNZ)) begin
      return CUR_W'(MAX_NNZ);
    end
    return CUR_W'(w);
  endfunction

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign res_load  = (state == S_DONE) && (!res_valid || !res_stall);

  assign slot_w = 32'(slot);
  assign ca_w   = 32'(col_a);
  assign ca1_w  = ca_w + 32'd1;
  assign cb_w   = 32'(cb);
  assign cb1_w  = cb_w + 32'd1;

  assign query_ok = (neighbour_code != 11'd0) && (ca_w < 32'(MAX_DIM)) &&
                    ((32'(neighbour_code) - 32'd1) < 32'(MAX_DIM));

  assign col_we = accept && (cmd == CMD_PTR) && (slot_w <= 32'(MAX_DIM));
  assign nz_we  = accept && (cmd == CMD_ENTRY) && (slot_w < 32'(MAX_NNZ));

  assign row_a = nz_rdata_a[VALUE_WIDTH +: ROW_W];
  assign row_b = nz_rdata_b[VALUE_WIDTH +: ROW_W];

  scdp_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_DIM + 1),
    .AW    (DIM_AW)
  ) u_col_ram (
    .clk     (clk),
    .we      (col_we),
    .waddr   (slot_w[DIM_AW-1:0]),
    .wdata   (pointer_value),
    .raddr_a (col_raddr_a),
    .rdata_a (col_rdata_a),
    .raddr_b (col_raddr_b),
    .rdata_b (col_rdata_b)
  );

  scdp_ram #(
    .WIDTH (NZ_W),
    .DEPTH (MAX_NNZ),
    .AW    (NNZ_AW)
  ) u_nz_ram (
    .clk     (clk),
    .we      (nz_we),
    .waddr   (slot_w[NNZ_AW-1:0]),
    .wdata   ({row_index, entry_value[VALUE_WIDTH-1:0]}),
    .raddr_a (nz_raddr_a),
    .rdata_a (nz_rdata_a),
    .raddr_b (nz_raddr_b),
    .rdata_b (nz_rdata_b)
  );

  scdp_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (nz_rdata_a[VALUE_WIDTH-1:0]),
    .b   (nz_rdata_b[VALUE_WIDTH-1:0]),
    .acc (acc),
    .sat (acc_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k  <= k_next;
    ke <= ke_next;
    l  <= l_next;
    le <= le_next;
    if (accept) begin
      cb <= neighbour_code - 11'd1;
    end
  end

  // The RAM addresses are driven from the next cursor values, so the row
  // data of the current cursors is present in every merge cycle.
  always_comb begin
    state_next    = state;
    k_next        = k;
    ke_next       = ke;
    l_next        = l;
    le_next       = le;
    col_raddr_a   = cb_w[DIM_AW-1:0];
    col_raddr_b   = cb1_w[DIM_AW-1:0];
    nz_raddr_a    = NNZ_AW'(k);
    nz_raddr_b    = NNZ_AW'(l);
    mac_ctl.clear = 1'b0;
    mac_ctl.fire  = 1'b0;

    unique case (state)
      S_IDLE: begin
        col_raddr_a = ca_w[DIM_AW-1:0];
        col_raddr_b = ca1_w[DIM_AW-1:0];
        if (accept && (cmd == CMD_QUERY)) begin
          mac_ctl.clear = 1'b1;
          state_next    = query_ok ? S_COLA : S_DONE;
        end
      end
      S_COLA: begin
        k_next     = clamp_ptr(col_rdata_a);
        ke_next    = clamp_ptr(col_rdata_b);
        state_next = S_COLB;
      end
      S_COLB: begin
        l_next     = clamp_ptr(col_rdata_a);
        le_next    = clamp_ptr(col_rdata_b);
        nz_raddr_b = NNZ_AW'(l_next);
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if ((k < ke) && (l < le)) begin
          if (row_a < row_b) begin
            k_next = k + CUR_W'(1);
          end else if (row_a > row_b) begin
            l_next = l + CUR_W'(1);
          end else begin
            k_next       = k + CUR_W'(1);
            l_next       = l + CUR_W'(1);
            mac_ctl.fire = 1'b1;
          end
          nz_raddr_a = NNZ_AW'(k_next);
          nz_raddr_b = NNZ_AW'(l_next);
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last product was added at the end of the final merge cycle,
        // so the accumulator already holds the finished sum here.
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      dot_product <= acc;
      saturated   <= acc_sat;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the sparse column dot product block.
`timescale 1ns / 100ps

module tb_top;
  import scdp_pkg::*;

  localparam int DIM           = 1024;
  localparam int NNZ           = 65536;
  localparam int ITEMS         = 1050;
  localparam int HOLD_AT       = 40;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SHOWN_ERRORS  = 10;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [15:0]      slot;
    logic [PTR_W-1:0] ptr;
    logic [ROW_W-1:0] row;
    logic [31:0]      val;
    logic [9:0]       ca;
    logic [10:0]      code;
    logic             drain_first;
  } cmd_beat_t;

  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic             flag;
  } dot_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cmd_valid = 1'b0;
  logic                    cmd_stall;
  logic [1:0]              cmd = CMD_PTR;
  logic [15:0]             slot = '0;
  logic [PTR_W-1:0]        pointer_value = '0;
  logic [ROW_W-1:0]        row_index = '0;
  logic signed [31:0]      entry_value = '0;
  logic [9:0]              col_a = '0;
  logic [10:0]             neighbour_code = '0;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  logic signed [ACC_W-1:0] dot_product;
  logic                    saturated;

  // Contents of the block's stores as the accepted beats leave them.
  logic [PTR_W-1:0] ptr_mem [0:DIM];
  logic [ROW_W-1:0] row_mem [0:NNZ-1];
  logic [31:0]      val_mem [0:NNZ-1];

  // What the stimulus generator knows it has written so far.
  logic [PTR_W-1:0] gen_ptr [0:DIM];
  bit               ptr_set [0:DIM];
  bit               slot_set [0:NNZ-1];
  int               known_cols [$];
  int               planned_items = 0;

  cmd_beat_t   cmd_plan [$];
  dot_result_t pending_dots [$];

  cmd_beat_t   next_beat;
  dot_result_t want;
  int          send_wait = 0;
  int          send_calm = 0;
  int          stall_left = 0;
  int          recv_calm = 0;
  int          hold;
  int          results_seen = 0;
  int          fails = 0;
  int          cycle_count;

  sparse_column_dot_product #(
    .MAX_DIM     (DIM),
    .MAX_NNZ     (NNZ),
    .VALUE_WIDTH (32)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .slot           (slot),
    .pointer_value  (pointer_value),
    .row_index      (row_index),
    .entry_value    (entry_value),
    .col_a          (col_a),
    .neighbour_code (neighbour_code),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .dot_product    (dot_product),
    .saturated      (saturated)
  );

  always #5 clk = ~clk;

  // Bounds of a column from its two pointers, clamped, with a reversed pair made empty.
  function automatic void col_span(input logic [PTR_W-1:0] start_ptr,
                                   input logic [PTR_W-1:0] end_ptr,
                                   output int lo, output int hi);
    lo = int'(start_ptr);
    hi = int'(end_ptr);
    if (lo > NNZ) lo = NNZ;
    if (hi > NNZ) hi = NNZ;
    if (hi < lo) hi = lo;
  endfunction

  function automatic dot_result_t dot_product_of(input logic [9:0] ca,
                                                 input logic [10:0] code);
    dot_result_t r;
    int k, ke, l, le;
    logic signed [63:0] va, vb, term, sum;
    r.dot = '0;
    r.flag = 1'b0;
    if (code != 0 && code <= DIM) begin
      col_span(ptr_mem[ca], ptr_mem[ca + 1], k, ke);
      col_span(ptr_mem[code - 1], ptr_mem[code], l, le);
      while (k < ke && l < le) begin
        if (row_mem[k] < row_mem[l]) begin
          k++;
        end else if (row_mem[k] > row_mem[l]) begin
          l++;
        end else begin
          va = $signed(val_mem[k]);
          vb = $signed(val_mem[l]);
          term = va * vb;
          sum = r.dot + term;
          // An overflow clamps towards its own direction and stays sticky.
          if (r.dot[63] == term[63] && sum[63] != r.dot[63]) begin
            r.flag = 1'b1;
            sum = r.dot[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
          end
          r.dot = sum;
          k++;
          l++;
        end
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(inout int calm_run);
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_run = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic cmd_beat_t noisy_beat(input logic [1:0] op);
    cmd_beat_t b;
    b.op = op;
    b.slot = 16'($urandom);
    b.ptr = PTR_W'($urandom);
    b.row = ROW_W'($urandom);
    b.val = $urandom;
    b.ca = 10'($urandom);
    b.code = 11'($urandom);
    b.drain_first = 1'b0;
    return b;
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h01FF_FFFF)
                                        : -$urandom_range(0, 32'h01FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // A query may only be issued when every pointer and slot it reads has been written.
  function automatic bit query_safe(input int ca, input int code);
    int lo, hi, s;
    bit safe;
    if (code == 0 || code > DIM) return 1'b1;
    if (!ptr_set[ca] || !ptr_set[ca + 1] || !ptr_set[code - 1] || !ptr_set[code])
      return 1'b0;
    safe = 1'b1;
    col_span(gen_ptr[ca], gen_ptr[ca + 1], lo, hi);
    for (s = lo; s < hi; s++) if (!slot_set[s]) safe = 1'b0;
    col_span(gen_ptr[code - 1], gen_ptr[code], lo, hi);
    for (s = lo; s < hi; s++) if (!slot_set[s]) safe = 1'b0;
    return safe;
  endfunction

  task automatic push_ptr(input int col, input int value);
    cmd_beat_t b;
    b = noisy_beat(CMD_PTR);
    b.slot = 16'(col);
    b.ptr = PTR_W'(value);
    if (col <= DIM) begin
      gen_ptr[col] = b.ptr;
      ptr_set[col] = 1'b1;
      planned_items++;
    end
    cmd_plan.push_back(b);
  endtask

  task automatic push_entry(input int at, input int row, input logic [31:0] v);
    cmd_beat_t b;
    b = noisy_beat(CMD_ENTRY);
    b.slot = 16'(at);
    b.row = ROW_W'(row);
    b.val = v;
    slot_set[at] = 1'b1;
    planned_items++;
    cmd_plan.push_back(b);
  endtask

  task automatic push_query(input int ca, input int code);
    cmd_beat_t b;
    b = noisy_beat(CMD_QUERY);
    b.ca = 10'(ca);
    b.code = query_safe(ca, code) ? 11'(code) : 11'd0;
    planned_items++;
    cmd_plan.push_back(b);
  endtask

  task automatic push_drain_pause();
    cmd_beat_t b;
    b = noisy_beat(CMD_UNUSED);
    b.drain_first = 1'b1;
    cmd_plan.push_back(b);
  endtask

  task automatic ask_known_pairs(input int count);
    int i, ca, cb;
    for (i = 0; i < count; i++) begin
      if (known_cols.size() == 0) begin
        push_query($urandom_range(0, DIM - 1), 0);
      end else begin
        ca = known_cols[$urandom_range(0, known_cols.size() - 1)];
        cb = known_cols[$urandom_range(0, known_cols.size() - 1)];
        case ($urandom_range(0, 9))
          0: push_query($urandom_range(0, DIM - 1), 0);
          1: push_query(ca, $urandom_range(DIM + 1, 2047));
          2: push_query(ca, ca + 1);
          default: push_query(ca, cb + 1);
        endcase
      end
    end
  endtask

  // Lays out a run of adjacent columns with their entries in consecutive slots.
  task automatic add_column_group();
    int cols, first_col, slot_at, total, i, j, r, row;
    int lens [6];
    bit wide_rows, sorted;
    cols = $urandom_range(1, 6);
    first_col = $urandom_range(0, DIM - cols);
    total = 0;
    for (i = 0; i < cols; i++) begin
      lens[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      total += lens[i];
    end
    slot_at = $urandom_range(0, NNZ - total);
    wide_rows = ($urandom_range(0, 4) == 0);
    for (i = 0; i < cols; i++) begin
      push_ptr(first_col + i, slot_at);
      sorted = ($urandom_range(0, 15) != 0);
      r = wide_rows ? $urandom_range(0, 200) : $urandom_range(0, 3);
      for (j = 0; j < lens[i]; j++) begin
        if (sorted) begin
          row = (r > DIM - 1) ? DIM - 1 : r;
          if (wide_rows) r += $urandom_range(1, 60);
          else r += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        end else begin
          row = wide_rows ? $urandom_range(0, DIM - 1) : $urandom_range(0, 31);
        end
        push_entry(slot_at, row, draw_value());
        slot_at++;
      end
      known_cols.push_back(first_col + i);
      if (known_cols.size() > 40) void'(known_cols.pop_front());
    end
    push_ptr(first_col + cols, slot_at);
  endtask

  // Sender: applies each accepted beat to the expected store contents, then
  // offers the next planned beat after its drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        case (cmd)
          CMD_PTR: if (slot <= DIM) ptr_mem[slot] = pointer_value;
          CMD_ENTRY: begin
            row_mem[slot] = row_index;
            val_mem[slot] = entry_value;
          end
          CMD_QUERY: pending_dots.push_back(dot_product_of(col_a, neighbour_code));
          default: ;
        endcase
      end
      if (!cmd_valid || !cmd_stall) begin
        if (send_wait != 0) begin
          cmd_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (cmd_plan.size() == 0) begin
          cmd_valid <= 1'b0;
        end else if (cmd_plan[0].drain_first) begin
          cmd_valid <= 1'b0;
          if (pending_dots.size() == 0) void'(cmd_plan.pop_front());
        end else begin
          next_beat = cmd_plan.pop_front();
          cmd <= next_beat.op;
          slot <= next_beat.slot;
          pointer_value <= next_beat.ptr;
          row_index <= next_beat.row;
          entry_value <= $signed(next_beat.val);
          col_a <= next_beat.ca;
          neighbour_code <= next_beat.code;
          cmd_valid <= 1'b1;
          send_wait <= draw_wait(send_calm);
        end
      end
    end
  end

  // Receiver: checks each result beat and draws its own stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (pending_dots.size() == 0) begin
          fails++;
          if (fails <= SHOWN_ERRORS)
            $display("unexpected result beat: dot %h sat %b", dot_product, saturated);
        end else begin
          want = pending_dots.pop_front();
          if (dot_product !== want.dot || saturated !== want.flag) begin
            fails++;
            if (fails <= SHOWN_ERRORS)
              $display("dot product mismatch: expected %h sat %b, got %h sat %b",
                       want.dot, want.flag, dot_product, saturated);
          end
        end
        // One long hold-off lets the block back up into its input.
        hold = (results_seen == HOLD_AT) ? LONG_HOLD : draw_wait(recv_calm);
      end else if (stall_left != 0) begin
        hold = stall_left - 1;
      end else if (recv_calm == 0 && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 8);
      end else begin
        hold = 0;
      end
      stall_left <= hold;
      res_stall <= (hold != 0);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int pick, c, at;
    bit drain_done;

    // Directed part: ignored beats, clamped and reversed bounds, duplicate
    // rows, saturation both ways, an empty column and the out-of-range codes.
    cmd_plan.push_back(noisy_beat(CMD_UNUSED));
    push_ptr(65535, 5);
    push_ptr(DIM + 1, 7);
    push_ptr(0, 65532);
    push_ptr(1, 131071);
    push_ptr(2, 65534);
    push_ptr(DIM - 1, 20);
    push_ptr(DIM, 24);
    push_entry(65532, 0, 32'h8000_0000);
    push_entry(65533, 0, 32'h8000_0000);
    push_entry(65534, DIM - 1, 32'h8000_0000);
    push_entry(65535, DIM - 1, 32'h7FFF_FFFF);
    push_entry(20, 0, 32'h7FFF_FFFF);
    push_entry(21, 0, 32'h7FFF_FFFF);
    push_entry(22, DIM - 1, 32'h7FFF_FFFF);
    push_entry(23, DIM - 1, 32'h8000_0000);
    push_query(0, 1);
    push_query(0, DIM);
    push_query(DIM - 1, DIM);
    push_query(1, 1);
    push_query($urandom_range(0, DIM - 1), 0);
    push_query(0, DIM + 1);
    push_query(DIM - 1, 2047);
    push_drain_pause();
    known_cols.push_back(0);
    known_cols.push_back(1);
    known_cols.push_back(DIM - 1);

    drain_done = 1'b0;
    while (planned_items < ITEMS) begin
      if (!drain_done && planned_items >= ITEMS / 2) begin
        push_drain_pause();
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_column_group();
        ask_known_pairs($urandom_range(2, 6));
      end else if (pick < 75) begin
        ask_known_pairs($urandom_range(1, 4));
      end else if (pick < 85) begin
        cmd_plan.push_back(noisy_beat(CMD_UNUSED));
        push_ptr($urandom_range(DIM + 1, 65535), $urandom_range(0, 131071));
        push_query($urandom_range(0, DIM - 1), $urandom_range(0, 1) ? 0
                                                 : $urandom_range(DIM + 1, 2047));
      end else if (pick < 95) begin
        at = $urandom_range(0, NNZ - 1);
        if (known_cols.size() != 0 && $urandom_range(0, 1) == 0) begin
          c = known_cols[$urandom_range(0, known_cols.size() - 1)];
          if (int'(gen_ptr[c]) < NNZ) at = int'(gen_ptr[c]);
        end
        push_entry(at, $urandom_range(0, DIM - 1), draw_value());
      end else begin
        push_ptr($urandom_range(0, DIM), $urandom_range(0, 131071));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_plan.size() != 0 || cmd_valid || pending_dots.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0 && pending_dots.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/scdp_pkg.sv
hw/rtl/scdp_ram.sv
hw/rtl/scdp_mac.sv
hw/rtl/sparse_column_dot_product.sv
tb/sv/tb_top.sv
